// ===== rtl/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
// No dependencies; u8dec_core and the top level import this package.
package u8dec_pkg;

  // input word: one byte of the string plus its end mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_char;
    logic        end_of_string;
  } out_item_t;

  // decoder modes
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeTwo   = 2'd1;
  localparam logic [1:0] ModeThree = 2'd2;
  localparam logic [1:0] ModeSkip  = 2'd3;

  // substitute character after reset ('?')
  localparam logic [15:0] SubReset = 16'h003F;

endpackage

// ===== rtl/u8dec_chan_if.sv =====
// Valid/ready channel carrying one word of a generic payload type.
// Depends on nothing; payload types come from u8dec_pkg at instantiation.
interface u8dec_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/u8dec_stage.sv =====
// One register stage of a valid/ready pipeline, generic in its payload.
// Depends on nothing.
module u8dec_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  // stage can take a word when empty or when its word leaves this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== rtl/u8dec_core.sv =====
// Decode state and the per-byte next-state and result logic.
// Depends on u8dec_pkg.
module u8dec_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  u8dec_pkg::in_item_t   item_i,
  input  logic [15:0]           sub_i,
  output logic                  emit_o,
  output u8dec_pkg::out_item_t  res_o
);
  import u8dec_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic [2:0]  pend_q, pend_d;
  logic [15:0] part_q, part_d;
  logic [2:0]  skip_cnt;
  logic [7:0]  b;
  logic        last;

  assign b    = item_i.data_byte;
  assign last = item_i.last_byte;

  // tail length of a 4, 5 or 6 byte lead, zero for anything else
  always_comb begin
    if (b[7:3] == 5'b11110) begin
      skip_cnt = 3'd3;
    end else if (b[7:2] == 6'b111110) begin
      skip_cnt = 3'd4;
    end else if (b[7:1] == 7'b1111110) begin
      skip_cnt = 3'd5;
    end else begin
      skip_cnt = 3'd0;
    end
  end

  // next state and result for the current byte
  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    part_d = part_q;
    emit_o = 1'b0;
    res_o  = '0;
    case (mode_q)
      ModeIdle: begin
        if (!b[7]) begin
          emit_o = 1'b1;
          res_o  = '{code_unit: {8'h00, b}, has_char: 1'b1, end_of_string: last};
        end else if (b[7:5] == 3'b110) begin
          if (last) begin
            emit_o = 1'b1;
            res_o  = '{code_unit: sub_i, has_char: 1'b1, end_of_string: 1'b1};
          end else begin
            mode_d = ModeTwo;
            pend_d = 3'd1;
            part_d = {5'b0, b[4:0], 6'b0};
          end
        end else if (b[7:4] == 4'b1110) begin
          if (last) begin
            emit_o = 1'b1;
            res_o  = '{code_unit: sub_i, has_char: 1'b1, end_of_string: 1'b1};
          end else begin
            mode_d = ModeThree;
            pend_d = 3'd2;
            part_d = {b[3:0], 12'b0};
          end
        end else begin
          emit_o = 1'b1;
          res_o  = '{code_unit: sub_i, has_char: 1'b1, end_of_string: last};
          if (!last && skip_cnt != 3'd0) begin
            mode_d = ModeSkip;
            pend_d = skip_cnt;
          end
        end
      end
      ModeTwo: begin
        emit_o = 1'b1;
        res_o  = '{code_unit: part_q | {10'b0, b[5:0]}, has_char: 1'b1,
                   end_of_string: last};
        mode_d = ModeIdle;
        pend_d = 3'd0;
        part_d = '0;
      end
      ModeThree: begin
        if (pend_q >= 3'd2) begin
          if (last) begin
            emit_o = 1'b1;
            res_o  = '{code_unit: sub_i, has_char: 1'b1, end_of_string: 1'b1};
            mode_d = ModeIdle;
            pend_d = 3'd0;
            part_d = '0;
          end else begin
            part_d = part_q | {4'b0, b[5:0], 6'b0};
            pend_d = 3'd1;
          end
        end else begin
          emit_o = 1'b1;
          res_o  = '{code_unit: part_q | {10'b0, b[5:0]}, has_char: 1'b1,
                     end_of_string: last};
          mode_d = ModeIdle;
          pend_d = 3'd0;
          part_d = '0;
        end
      end
      ModeSkip: begin
        if (last) begin
          emit_o = 1'b1;
          res_o  = '{code_unit: 16'h0000, has_char: 1'b0, end_of_string: 1'b1};
          mode_d = ModeIdle;
          pend_d = 3'd0;
          part_d = '0;
        end else if (pend_q <= 3'd1) begin
          mode_d = ModeIdle;
          pend_d = 3'd0;
          part_d = '0;
        end else begin
          pend_d = pend_q - 3'd1;
        end
      end
      default: begin
        mode_d = ModeIdle;
        pend_d = 3'd0;
        part_d = '0;
      end
    endcase
  end

  // decode state, advanced once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      pend_q <= 3'd0;
      part_q <= '0;
    end else if (take_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

// ===== rtl/utf8_to_ucs2_decoder_top.sv =====
// Top level of the UTF-8 to 16-bit code unit decoder.
// Depends on u8dec_pkg, u8dec_chan_if, u8dec_stage and u8dec_core.
//
// Usage
//   in_i  : sink channel, one word per byte (data_byte, last_byte)
//   out_o : source channel, one word per decoded code unit or end marker
//           (code_unit, has_char, end_of_string)
//   cfg_i : sink channel, write data is the 16-bit substitute character;
//           always ready, write only while the decoder is idle
//   Bytes pass through an input register, the decode logic and a result
//   register. A byte that yields a result shows on out_o in the cycle
//   after it is taken; bytes that yield nothing are consumed and dropped.
//   Throughput is one byte per cycle while out_o does not stall, set by
//   the single decode stage. When out_o stalls, the result register holds
//   its word and one more byte waits in the input register; in_i drops
//   ready only once both are full. Bytes that yield no result still drain
//   during a stall. Reset empties both registers, returns the decoder to
//   idle and sets the substitute character to '?'.
module utf8_to_ucs2_decoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8dec_chan_if.sink   in_i,
  u8dec_chan_if.source out_o,
  u8dec_chan_if.sink   cfg_i
);
  import u8dec_pkg::*;

  logic        in_vld;
  in_item_t    in_item;
  logic        take;
  logic        emit;
  out_item_t   res;
  logic        out_rdy;
  logic        core_rdy;
  logic [15:0] sub_q;

  // substitute character register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= SubReset;
    end else if (cfg_i.valid) begin
      sub_q <= cfg_i.data[15:0];
    end
  end

  // input register
  u8dec_stage #(.T(in_item_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_i.data),
    .valid_o (in_vld),
    .ready_i (core_rdy),
    .data_o  (in_item)
  );

  // a byte leaves the input register when its result has room or it has none
  assign core_rdy = !emit || out_rdy;
  assign take     = in_vld && core_rdy;

  // decode logic and state
  u8dec_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_item),
    .sub_i  (sub_q),
    .emit_o (emit),
    .res_o  (res)
  );

  // result register
  u8dec_stage #(.T(out_item_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld && emit),
    .ready_o (out_rdy),
    .data_i  (res),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_o.data)
  );

endmodule
